// ===== rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_BLOCKS   = 2048;

    localparam int SIZE_W   = 16;
    localparam int ADDR_W   = 16;
    localparam int MARGIN_W = 10;
    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int OFS_W    = $clog2(HEAP_BYTES) + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } t_entry;

endpackage

// ===== rtl/first_fit_heap_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator over an address-ordered block table held in one
// synchronous RAM; splits on allocate, coalesces neighbours on free.
// ----------------------------------------------------------------------------
//  channel   | direction | fields (lowest bit first)
//  s_axis    | in        | tuser: opcode ; tdata: request_size, free_address
//  m_axis    | out       | tuser: status ; tdata: address
//  cfg       | in        | data: split_margin
//
//  One transaction at a time. Every table entry visited is read from RAM and
//  then checked, so the time an operation takes grows with n, the number of
//  entries walked plus those shifted on a split or merge. After reset, entry 0
//  is written as the single free block before requests are taken.
//  The result register lets a new request in while a result awaits pickup.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [31:0]                   i_s_axis_tdata,  // request_size, free_address
    input  logic                          i_s_axis_tuser,  // opcode
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [15:0]                   o_m_axis_tdata,  // address
    output logic [1:0]                    o_m_axis_tuser,  // status
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffha_pkg::MARGIN_W-1:0] i_cfg_data
);

    localparam int IW = ffha_pkg::IDX_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int OW = ffha_pkg::OFS_W;
    localparam int SW = ffha_pkg::SIZE_W;

    localparam logic [4:0] S_INIT    = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_SCAN_RD = 5'd2;
    localparam logic [4:0] S_SCAN_CK = 5'd3;
    localparam logic [4:0] S_SH_RD   = 5'd4;
    localparam logic [4:0] S_SH_WR   = 5'd5;
    localparam logic [4:0] S_A_NEW   = 5'd6;
    localparam logic [4:0] S_A_CUR   = 5'd7;
    localparam logic [4:0] S_PREV_RD = 5'd8;
    localparam logic [4:0] S_PREV_CK = 5'd9;
    localparam logic [4:0] S_RM_RD   = 5'd10;
    localparam logic [4:0] S_RM_WR   = 5'd11;
    localparam logic [4:0] S_NEXT_RD = 5'd12;
    localparam logic [4:0] S_NEXT_CK = 5'd13;
    localparam logic [4:0] S_F_WR    = 5'd14;
    localparam logic [4:0] S_DONE    = 5'd15;

    localparam logic [SW-1:0] HDR     = SW'(ffha_pkg::HEADER_BYTES);
    localparam logic [OW-1:0] HDR_O   = OW'(ffha_pkg::HEADER_BYTES);
    localparam logic [SW-1:0] INIT_SZ =
        SW'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES);
    localparam logic [CW-1:0] MAXC    = CW'(ffha_pkg::MAX_BLOCKS);

    // block table
    ffha_pkg::t_entry r_mem [ffha_pkg::MAX_BLOCKS];
    ffha_pkg::t_entry r_rdata;

    // control
    logic [4:0]                    r_state, n_state;
    logic [4:0]                    r_ret, n_ret;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_out_valid, n_out_valid;
    logic [ffha_pkg::MARGIN_W-1:0] r_margin;

    // payload
    logic              r_op, n_op;
    logic [SW-1:0]     r_req, n_req;
    logic [SW-1:0]     r_faddr, n_faddr;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_k, n_k;
    logic [OW-1:0]     r_ofs, n_ofs;
    logic [SW-1:0]     r_cur, n_cur;
    logic [SW-1:0]     r_new, n_new;
    logic [1:0]        r_res_st, n_res_st;
    logic [15:0]       r_res_addr, n_res_addr;
    logic [1:0]        r_out_st, n_out_st;
    logic [15:0]       r_out_addr, n_out_addr;

    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    ffha_pkg::t_entry  wr_data;

    logic [CW-1:0]     idx1;
    logic [SW-1:0]     surplus;
    logic              do_split;
    logic [OW-1:0]     pay_ofs;

    assign idx1     = {1'b0, r_idx} + CW'(1);
    assign surplus  = r_rdata.size - r_req;
    assign do_split = (surplus > SW'(r_margin)) && (surplus >= HDR) && (r_count < MAXC);
    assign pay_ofs  = r_ofs + HDR_O;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_addr;
    assign o_m_axis_tuser  = r_out_st;

    // RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_req       = r_req;
        n_faddr     = r_faddr;
        n_idx       = r_idx;
        n_k         = r_k;
        n_ofs       = r_ofs;
        n_cur       = r_cur;
        n_new       = r_new;
        n_res_st    = r_res_st;
        n_res_addr  = r_res_addr;
        n_out_st    = r_out_st;
        n_out_addr  = r_out_addr;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = '{free: 1'b0, size: r_cur};

        // drop the result once the sink takes it
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                // single-entry arena after reset
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{free: 1'b1, size: INIT_SZ};
                n_count = CW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op    = i_s_axis_tuser;
                    n_req   = i_s_axis_tdata[15:0];
                    n_faddr = i_s_axis_tdata[31:16];
                    n_idx   = '0;
                    n_ofs   = '0;
                    if (i_s_axis_tuser == ffha_pkg::OP_ALLOC && i_s_axis_tdata[15:0] == '0) begin
                        n_res_st   = ffha_pkg::ST_ZERO;
                        n_res_addr = '0;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                n_cur = r_rdata.size;
                if (r_op == ffha_pkg::OP_ALLOC && r_rdata.free && r_rdata.size >= r_req) begin
                    n_res_st   = ffha_pkg::ST_OK;
                    n_res_addr = pay_ofs[15:0];
                    if (do_split) begin
                        n_cur   = r_req;
                        n_new   = surplus - HDR;
                        n_k     = r_count;
                        n_state = S_SH_RD;
                    end else begin
                        n_state = S_A_CUR;
                    end
                end else if (r_op == ffha_pkg::OP_FREE && pay_ofs == OW'(r_faddr)) begin
                    n_res_st   = ffha_pkg::ST_OK;
                    n_res_addr = '0;
                    n_state    = (r_idx != '0) ? S_PREV_RD : S_NEXT_RD;
                end else begin
                    n_ofs = r_ofs + HDR_O + OW'(r_rdata.size);
                    n_idx = r_idx + IW'(1);
                    if (idx1 == r_count) begin
                        n_res_st   = (r_op == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NOFIT
                                                                  : ffha_pkg::ST_UNKNOWN;
                        n_res_addr = '0;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SH_RD: begin
                // shift entries up to open a hole after the split block
                if (r_k == idx1) begin
                    n_state = S_A_NEW;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_k - CW'(1));
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k[IW-1:0];
                wr_data = r_rdata;
                n_k     = r_k - CW'(1);
                n_state = S_SH_RD;
            end
            S_A_NEW: begin
                wr_en   = 1'b1;
                wr_addr = idx1[IW-1:0];
                wr_data = '{free: 1'b1, size: r_new};
                n_count = r_count + CW'(1);
                n_state = S_A_CUR;
            end
            S_A_CUR: begin
                wr_en   = 1'b1;
                wr_data = '{free: 1'b0, size: r_cur};
                n_state = S_DONE;
            end
            S_PREV_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx - IW'(1);
                n_state = S_PREV_CK;
            end
            S_PREV_CK: begin
                if (r_rdata.free) begin
                    n_cur   = r_rdata.size + r_cur + HDR;
                    n_k     = {1'b0, r_idx};
                    n_idx   = r_idx - IW'(1);
                    n_ret   = S_NEXT_RD;
                    n_state = S_RM_RD;
                end else begin
                    n_state = S_NEXT_RD;
                end
            end
            S_RM_RD: begin
                // close the gap left by a merged entry
                if (r_k + CW'(1) >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = r_ret;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_k + CW'(1));
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k[IW-1:0];
                wr_data = r_rdata;
                n_k     = r_k + CW'(1);
                n_state = S_RM_RD;
            end
            S_NEXT_RD: begin
                if (idx1 < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = idx1[IW-1:0];
                    n_state = S_NEXT_CK;
                end else begin
                    n_state = S_F_WR;
                end
            end
            S_NEXT_CK: begin
                if (r_rdata.free) begin
                    n_cur   = r_cur + r_rdata.size + HDR;
                    n_k     = idx1;
                    n_ret   = S_F_WR;
                    n_state = S_RM_RD;
                end else begin
                    n_state = S_F_WR;
                end
            end
            S_F_WR: begin
                wr_en   = 1'b1;
                wr_data = '{free: 1'b1, size: r_cur};
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_addr  = r_res_addr;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ret       <= S_IDLE;
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
            r_margin    <= ffha_pkg::MARGIN_W'(128);
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_margin <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_req      <= n_req;
        r_faddr    <= n_faddr;
        r_idx      <= n_idx;
        r_k        <= n_k;
        r_ofs      <= n_ofs;
        r_cur      <= n_cur;
        r_new      <= n_new;
        r_res_st   <= n_res_st;
        r_res_addr <= n_res_addr;
        r_out_st   <= n_out_st;
        r_out_addr <= n_out_addr;
    end

endmodule

// ===== rtl/ffha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped before pickup");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second request taken while busy");

    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ffha_pkg::ST_OK |-> o_m_axis_tdata == '0)
        else $error("error result with nonzero address");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("activity right after reset");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
